[sv/isbf_pkg.sv]
package isbf_pkg;

    localparam int MAX_ENTRIES = 8;
    localparam int DIM_W       = 14;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int OUT_IDX_W   = 3;
    localparam int OUT_TOT_W   = 4;

    typedef enum logic [1:0] {
        OP_CLEAR      = 2'd0,
        OP_ADD        = 2'd1,
        OP_ADD_LIMITS = 2'd2,
        OP_QUERY      = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_EXACT    = 2'd0,
        KIND_RANGE    = 2'd1,
        KIND_FALLBACK = 2'd2,
        KIND_NONE     = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_DONE
    } state_t;

    typedef struct packed {
        op_t              op;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [DIM_W-1:0] min_width;
        logic [DIM_W-1:0] min_height;
        logic [DIM_W-1:0] max_width;
        logic [DIM_W-1:0] max_height;
    } item_t;

    typedef struct packed {
        logic [DIM_W-1:0] native_width;
        logic [DIM_W-1:0] native_height;
        logic [DIM_W-1:0] lower_width;
        logic [DIM_W-1:0] lower_height;
        logic [DIM_W-1:0] upper_width;
        logic [DIM_W-1:0] upper_height;
    } entry_t;

    typedef struct packed {
        logic                 found;
        logic [OUT_IDX_W-1:0] entry_index;
        kind_t                match_kind;
        logic                 newly_added;
        logic                 table_full;
        logic [OUT_TOT_W-1:0] entry_total;
    } result_t;

endpackage

[sv/image_size_best_fit_table.sv]
// Table of up to eight image sizes in a synchronous entry memory with one
// write and one read port. Opcodes: clear, add size, add size with limits,
// best fit query. An add or a query reads the stored entries one per cycle
// through the read port, stopping early on an exact size match; then a finish
// state (where an add writes) leads to the done state, which a clear enters
// directly. The next transaction is taken while the previous result waits in
// the output register. After reset the table is empty and ready at once.
module image_size_best_fit_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [13:0] s_width,
    input  logic [13:0] s_height,
    input  logic [13:0] s_min_width,
    input  logic [13:0] s_min_height,
    input  logic [13:0] s_max_width,
    input  logic [13:0] s_max_height,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_found,
    output logic [2:0]  m_entry_index,
    output logic [1:0]  m_match_kind,
    output logic        m_newly_added,
    output logic        m_table_full,
    output logic [3:0]  m_entry_total
);
    import isbf_pkg::*;

    item_t            in_item;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    entry_t           rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             res_valid;
    logic             res_ready;
    result_t          res;
    logic             m_valid_reg, m_valid_next;
    result_t          out_reg, out_next;

    assign in_item.op         = op_t'(s_opcode);
    assign in_item.width      = s_width;
    assign in_item.height     = s_height;
    assign in_item.min_width  = s_min_width;
    assign in_item.min_height = s_min_height;
    assign in_item.max_width  = s_max_width;
    assign in_item.max_height = s_max_height;

    isbf_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (in_item),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    isbf_mem u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // output register, loaded when empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
            if (res_valid) begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_found       = out_reg.found;
    assign m_entry_index = out_reg.entry_index;
    assign m_match_kind  = out_reg.match_kind;
    assign m_newly_added = out_reg.newly_added;
    assign m_table_full  = out_reg.table_full;
    assign m_entry_total = out_reg.entry_total;

endmodule

[sv/isbf_mem.sv]
module isbf_mem (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [isbf_pkg::IDX_W-1:0] wr_addr,
    input  isbf_pkg::entry_t          wr_data,
    input  logic                      rd_en,
    input  logic [isbf_pkg::IDX_W-1:0] rd_addr,
    output isbf_pkg::entry_t          rd_data
);
    import isbf_pkg::*;

    entry_t mem [MAX_ENTRIES];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/isbf_ctrl.sv]
module isbf_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  isbf_pkg::item_t            in_item,
    output logic                       rd_en,
    output logic [isbf_pkg::IDX_W-1:0] rd_addr,
    input  isbf_pkg::entry_t           rd_data,
    output logic                       wr_en,
    output logic [isbf_pkg::IDX_W-1:0] wr_addr,
    output isbf_pkg::entry_t           wr_data,
    output logic                       res_valid,
    input  logic                       res_ready,
    output isbf_pkg::result_t          res
);
    import isbf_pkg::*;

    state_t           state_reg, state_next;
    item_t            item_reg, item_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             exact_reg, exact_next;
    logic             have_best_reg, have_best_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [DIM_W-1:0] best_w_reg, best_w_next;
    logic [DIM_W-1:0] best_h_reg, best_h_next;
    logic             have_fb_reg, have_fb_next;
    logic [IDX_W-1:0] fb_idx_reg, fb_idx_next;
    logic [DIM_W-1:0] fb_w_reg, fb_w_next;
    logic [DIM_W-1:0] fb_h_reg, fb_h_next;
    result_t          res_reg, res_next;

    logic is_exact;
    logic in_range;
    logic meets_min;
    logic beats_best;
    logic beats_fb;
    logic more;
    logic room;
    logic is_add;

    // entry compares against the stored item
    assign is_exact   = rd_data.native_width == item_reg.width &&
                        rd_data.native_height == item_reg.height;
    assign in_range   = rd_data.lower_width <= item_reg.width &&
                        item_reg.width <= rd_data.upper_width &&
                        rd_data.lower_height <= item_reg.height &&
                        item_reg.height <= rd_data.upper_height;
    assign meets_min  = item_reg.width >= rd_data.lower_width &&
                        item_reg.height >= rd_data.lower_height;
    assign beats_best = rd_data.native_width > best_w_reg &&
                        rd_data.native_height > best_h_reg;
    assign beats_fb   = rd_data.native_width > fb_w_reg &&
                        rd_data.native_height > fb_h_reg;
    assign more       = (CNT_W'(idx_reg) + CNT_W'(1)) < count_reg;
    assign room       = count_reg < CNT_W'(MAX_ENTRIES);
    assign is_add     = item_reg.op == OP_ADD || item_reg.op == OP_ADD_LIMITS;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg      <= item_next;
        idx_reg       <= idx_next;
        exact_reg     <= exact_next;
        have_best_reg <= have_best_next;
        best_idx_reg  <= best_idx_next;
        best_w_reg    <= best_w_next;
        best_h_reg    <= best_h_next;
        have_fb_reg   <= have_fb_next;
        fb_idx_reg    <= fb_idx_next;
        fb_w_reg      <= fb_w_next;
        fb_h_reg      <= fb_h_next;
        res_reg       <= res_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    if (in_item.op == OP_CLEAR) begin
                        state_next = ST_DONE;
                    end else if (count_reg == '0) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (is_exact || !more) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and memory access
    always_comb begin
        in_ready  = 1'b0;
        res_valid = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = '0;
        wr_en     = 1'b0;
        wr_addr   = exact_reg ? best_idx_reg : count_reg[IDX_W-1:0];
        wr_data.native_width  = item_reg.width;
        wr_data.native_height = item_reg.height;
        if (item_reg.op == OP_ADD_LIMITS) begin
            wr_data.lower_width  = item_reg.min_width;
            wr_data.lower_height = item_reg.min_height;
            wr_data.upper_width  = item_reg.max_width;
            wr_data.upper_height = item_reg.max_height;
        end else begin
            wr_data.lower_width  = item_reg.width;
            wr_data.lower_height = item_reg.height;
            wr_data.upper_width  = item_reg.width;
            wr_data.upper_height = item_reg.height;
        end
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                rd_en    = in_valid;
            end
            ST_SCAN: begin
                rd_en   = !is_exact && more;
                rd_addr = idx_reg + IDX_W'(1);
            end
            ST_FINISH: begin
                if (is_add) begin
                    wr_en = exact_reg ? (item_reg.op == OP_ADD_LIMITS) : room;
                end
            end
            ST_DONE: begin
                res_valid = 1'b1;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    // scan bookkeeping and result
    always_comb begin
        item_next      = item_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        exact_next     = exact_reg;
        have_best_next = have_best_reg;
        best_idx_next  = best_idx_reg;
        best_w_next    = best_w_reg;
        best_h_next    = best_h_reg;
        have_fb_next   = have_fb_reg;
        fb_idx_next    = fb_idx_reg;
        fb_w_next      = fb_w_reg;
        fb_h_next      = fb_h_reg;
        res_next       = res_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    item_next      = in_item;
                    idx_next       = '0;
                    exact_next     = 1'b0;
                    have_best_next = 1'b0;
                    have_fb_next   = 1'b0;
                    if (in_item.op == OP_CLEAR) begin
                        count_next           = '0;
                        res_next.found       = 1'b0;
                        res_next.entry_index = '0;
                        res_next.match_kind  = KIND_EXACT;
                        res_next.newly_added = 1'b0;
                        res_next.table_full  = 1'b0;
                        res_next.entry_total = '0;
                    end
                end
            end
            ST_SCAN: begin
                if (is_exact) begin
                    exact_next    = 1'b1;
                    best_idx_next = idx_reg;
                end else if (in_range) begin
                    if (!have_best_reg || beats_best) begin
                        have_best_next = 1'b1;
                        best_idx_next  = idx_reg;
                        best_w_next    = rd_data.native_width;
                        best_h_next    = rd_data.native_height;
                    end
                end else if (meets_min) begin
                    if (!have_fb_reg || beats_fb) begin
                        have_fb_next = 1'b1;
                        fb_idx_next  = idx_reg;
                        fb_w_next    = rd_data.native_width;
                        fb_h_next    = rd_data.native_height;
                    end
                end
                if (!is_exact && more) begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_FINISH: begin
                res_next.found       = 1'b0;
                res_next.entry_index = '0;
                res_next.match_kind  = KIND_EXACT;
                res_next.newly_added = 1'b0;
                res_next.table_full  = 1'b0;
                res_next.entry_total = OUT_TOT_W'(count_reg);
                if (is_add) begin
                    if (exact_reg) begin
                        res_next.found       = 1'b1;
                        res_next.entry_index = OUT_IDX_W'(best_idx_reg);
                    end else if (room) begin
                        count_next           = count_reg + CNT_W'(1);
                        res_next.found       = 1'b1;
                        res_next.entry_index = OUT_IDX_W'(count_reg[IDX_W-1:0]);
                        res_next.newly_added = 1'b1;
                        res_next.entry_total = OUT_TOT_W'(count_reg + CNT_W'(1));
                    end else begin
                        res_next.table_full = 1'b1;
                    end
                end else if (exact_reg) begin
                    res_next.found       = 1'b1;
                    res_next.entry_index = OUT_IDX_W'(best_idx_reg);
                end else if (have_best_reg) begin
                    res_next.found       = 1'b1;
                    res_next.entry_index = OUT_IDX_W'(best_idx_reg);
                    res_next.match_kind  = KIND_RANGE;
                end else if (have_fb_reg) begin
                    res_next.found       = 1'b1;
                    res_next.entry_index = OUT_IDX_W'(fb_idx_reg);
                    res_next.match_kind  = KIND_FALLBACK;
                end else begin
                    res_next.match_kind = KIND_NONE;
                end
            end
            default: begin
                res_next = res_reg;
            end
        endcase
    end

    assign res = res_reg;

endmodule
